/* design/assert_macros.svh */
// Assertion helpers included by the convert unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every cycle outside reset
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/pwc_pkg.sv */
package pwc_pkg;

   typedef enum logic [3:0] {
      KIND_NONE   = 4'd0,
      KIND_BOOL   = 4'd1,
      KIND_BYTE   = 4'd2,
      KIND_CHAR   = 4'd3,
      KIND_SHORT  = 4'd4,
      KIND_INT    = 4'd5,
      KIND_LONG   = 4'd6,
      KIND_FLOAT  = 4'd7,
      KIND_DOUBLE = 4'd8,
      KIND_VOID   = 4'd9
   } kind_type;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_MISMATCH = 1'b1;

   // Decoded view of one request, handed from the check stage to the datapath
   typedef struct packed {
      logic     allowed;
      kind_type src;
      kind_type tgt;
   } conv_ctl_type;

   // Widening rule check
   function automatic logic widen_ok(input logic [3:0] s, input logic [3:0] t);
      logic ok;
      ok = 1'b0;
      if (s <= KIND_VOID && t <= KIND_VOID) begin
         if (s == t) begin
            ok = (s != KIND_NONE) && (s != KIND_VOID);
         end else begin
            case (s)
               KIND_BYTE: ok = (t == KIND_SHORT) || (t >= KIND_INT && t <= KIND_DOUBLE);
               KIND_SHORT, KIND_CHAR: ok = (t >= KIND_INT && t <= KIND_DOUBLE);
               KIND_INT: ok = (t >= KIND_LONG && t <= KIND_DOUBLE);
               KIND_LONG: ok = (t == KIND_FLOAT) || (t == KIND_DOUBLE);
               KIND_FLOAT: ok = (t == KIND_DOUBLE);
               default: ok = 1'b0;
            endcase
         end
      end
      return ok;
   endfunction

endpackage

/* design/pwc_int_to_fp.sv */
// Signed 64-bit integer to float or double, round to nearest even
module pwc_int_to_fp
   import pwc_pkg::*;
(
   input  logic [63:0] value,
   input  logic        to_double,
   output logic [63:0] fp_bits
);
   logic        neg;
   logic [63:0] mag;
   logic [5:0]  msb;
   logic [63:0] norm;
   logic [52:0] mant_d;
   logic [23:0] mant_f;
   logic        guard;
   logic        sticky;
   logic        lsb;
   logic        rnd_up;
   logic [53:0] mant_r;
   logic [10:0] exp_v;

   always_comb begin
      neg = value[63];
      mag = neg ? (64'd0 - value) : value;
      // leading one position
      msb = 6'd0;
      for (int i = 0; i < 64; i++) begin
         if (mag[i]) msb = 6'(i);
      end
      norm = mag << (6'd63 - msb);
      mant_d = norm[63:11];
      mant_f = norm[63:40];
      if (to_double) begin
         lsb    = norm[11];
         guard  = norm[10];
         sticky = |norm[9:0];
         rnd_up = guard && (sticky || lsb);
         mant_r = {1'b0, mant_d} + {53'd0, rnd_up};
      end else begin
         lsb    = norm[40];
         guard  = norm[39];
         sticky = |norm[38:0];
         rnd_up = guard && (sticky || lsb);
         mant_r = {29'd0, ({1'b0, mant_f} + {24'd0, rnd_up})};
      end
      fp_bits = 64'd0;
      if (mag != 64'd0) begin
         if (to_double) begin
            exp_v = 11'(msb) + 11'd1023 + {10'd0, mant_r[53]};
            fp_bits = {neg, exp_v, mant_r[53] ? mant_r[52:1] : mant_r[51:0]};
         end else begin
            exp_v = 11'(msb) + 11'd127 + {10'd0, mant_r[24]};
            fp_bits = {32'd0, neg, exp_v[7:0],
                       mant_r[24] ? mant_r[23:1] : mant_r[22:0]};
         end
      end else begin
         exp_v = 11'd0;
      end
   end
endmodule

/* design/primitive_widening_convert_unit.sv */
// Path: an accepted request is held in the input register, then in the result register; a result stall holds it.
// Throughput: one request per cycle while the result is not stalled; the conversion is one combinational pass.
// A stalled result holds; the input register takes one more request while the result waits.
// Reset (synchronous, active high) clears both valid flags; payload is not reset.
module primitive_widening_convert_unit
   import pwc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_source_kind,
   input  logic [63:0] req_source_bits,
   input  logic [3:0]  req_target_kind,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_status,
   output logic [63:0] rsp_result_bits
);
`include "assert_macros.svh"

   logic        in_vld_ff, in_vld_in;
   logic [3:0]  in_sk_ff, in_tk_ff;
   logic [63:0] in_bits_ff;
   logic        out_vld_ff, out_vld_in;
   logic        out_st_ff;
   logic [63:0] out_bits_ff;

   conv_ctl_type ctl;
   logic [63:0]  ext_val;
   logic [63:0]  fp_val;
   logic [63:0]  f2d;
   logic [63:0]  res;
   logic         advance;
   logic [7:0]   fe;
   logic [22:0]  fm;
   logic [4:0]   lz;
   logic [22:0]  fm_n;

   // Result register moves when empty or drained
   assign advance   = !out_vld_ff || !rsp_stall;
   assign req_stall = in_vld_ff && !advance;
   assign in_vld_in = (req_valid && !req_stall) || (in_vld_ff && !advance);
   assign out_vld_in = advance ? in_vld_ff : out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_sk_ff   <= req_source_kind;
         in_tk_ff   <= req_target_kind;
         in_bits_ff <= req_source_bits;
      end
      if (advance && in_vld_ff) begin
         out_st_ff   <= ctl.allowed ? STATUS_OK : STATUS_MISMATCH;
         out_bits_ff <= res;
      end
   end

   // Decode
   always_comb begin
      ctl.allowed = widen_ok(in_sk_ff, in_tk_ff);
      ctl.src     = kind_type'(in_sk_ff);
      ctl.tgt     = kind_type'(in_tk_ff);
   end

   // Sign or zero extension of the source
   always_comb begin
      case (ctl.src)
         KIND_BYTE:  ext_val = {{56{in_bits_ff[7]}}, in_bits_ff[7:0]};
         KIND_CHAR:  ext_val = {48'd0, in_bits_ff[15:0]};
         KIND_SHORT: ext_val = {{48{in_bits_ff[15]}}, in_bits_ff[15:0]};
         KIND_INT:   ext_val = {{32{in_bits_ff[31]}}, in_bits_ff[31:0]};
         default:    ext_val = in_bits_ff;
      endcase
   end

   pwc_int_to_fp u_i2f (
      .value     (ext_val),
      .to_double (ctl.tgt == KIND_DOUBLE),
      .fp_bits   (fp_val)
   );

   // Float to double, subnormals normalized
   always_comb begin
      fe = in_bits_ff[30:23];
      fm = in_bits_ff[22:0];
      lz = 5'd0;
      for (int i = 0; i < 23; i++) begin
         if (fm[i]) lz = 5'(22 - i);
      end
      fm_n = fm << (lz + 5'd1);
      if (fe == 8'hFF) begin
         f2d = {in_bits_ff[31], 11'h7FF,
                (fm == 23'd0) ? 52'd0 : {1'b1, fm[21:0], 29'd0}};
      end else if (fe == 8'd0) begin
         if (fm == 23'd0) f2d = {in_bits_ff[31], 63'd0};
         else f2d = {in_bits_ff[31], 11'd897 - 11'(lz) - 11'd1, fm_n, 29'd0};
      end else begin
         f2d = {in_bits_ff[31], 11'(fe) + 11'd896, fm, 29'd0};
      end
   end

   // Result select
   always_comb begin
      res = 64'd0;
      if (ctl.allowed) begin
         if (ctl.tgt == KIND_BOOL) res = {63'd0, |in_bits_ff};
         else if (ctl.src == KIND_FLOAT)
            res = (ctl.tgt == KIND_DOUBLE) ? f2d : {32'd0, in_bits_ff[31:0]};
         else if (ctl.src == KIND_DOUBLE) res = in_bits_ff;
         else begin
            case (ctl.tgt)
               KIND_LONG:   res = ext_val;
               KIND_FLOAT,
               KIND_DOUBLE: res = fp_val;
               default:     res = {32'd0, ext_val[31:0]};
            endcase
         end
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_status      = out_st_ff;
   assign rsp_result_bits = out_bits_ff;

   `ASSERT_IMP(a_mismatch_zero, clock, reset,
      rsp_valid && rsp_status == STATUS_MISMATCH, rsp_result_bits == 64'd0,
      "mismatch result not zero")
   `ASSERT_NEXT(a_hold_result, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_result_bits), "stalled result changed")
   `ASSERT_NEXT(a_pipe_move, clock, reset, in_vld_ff && advance, rsp_valid,
      "staged request lost")
endmodule
